// ===== hdl/region_membership_set_iterator_top_defines.svh =====
// assertion macros for the region membership set iterator
`ifndef REGION_MEMBERSHIP_SET_ITERATOR_TOP_DEFINES_SVH
`define REGION_MEMBERSHIP_SET_ITERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RMSI_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmsi assertion failed");
// next-cycle implication
`define RMSI_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmsi assertion failed");
`else
`define RMSI_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define RMSI_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif

`endif

// ===== hdl/rmsi_pkg.sv =====
// shared types and constants of the region membership set iterator
`timescale 1ns / 1ps

package rmsi_pkg;

	localparam int MAX_REGIONS_DEF = 1024;
	localparam int WORD_BITS_DEF   = 64;

	localparam int OP_W    = 3;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;
	localparam int CFG_W   = 11;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_ADD        = 3'd0,
		OP_REMOVE     = 3'd1,
		OP_CLEAR      = 3'd2,
		OP_QUERY      = 3'd3,
		OP_ITER_RESET = 3'd4,
		OP_ITER_NEXT  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ROUTE_DIRECT,
		ROUTE_INDEX,
		ROUTE_SCAN
	} route_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH,
		ST_EXEC,
		ST_SCAN,
		ST_DIRECT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load_addr;
		logic rd_en;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic   in_valid;
		route_t route;
		logic   scan_done;
		logic   out_free;
	} status_t;

endpackage

// ===== hdl/rmsi_if.sv =====
// request, response and configuration channel interfaces
`timescale 1ns / 1ps

interface rmsi_req_if;
	logic                           valid;
	logic                           ready;
	logic [rmsi_pkg::OP_W-1:0]      operation;
	logic [rmsi_pkg::INDEX_W-1:0]   region_index;

	modport source (output valid, operation, region_index, input ready);
	modport sink (input valid, operation, region_index, output ready);
endinterface

interface rmsi_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           success;
	logic [rmsi_pkg::INDEX_W-1:0]   found_index;
	logic                           exhausted;
	logic                           error;
	logic [rmsi_pkg::COUNT_W-1:0]   member_count;

	modport source (output valid, success, found_index, exhausted, error, member_count,
		input ready);
	modport sink (input valid, success, found_index, exhausted, error, member_count,
		output ready);
endinterface

interface rmsi_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rmsi_pkg::CFG_W-1:0]     regions_in_use;

	modport source (output valid, regions_in_use, input ready);
	modport sink (input valid, regions_in_use, output ready);
endinterface

// ===== hdl/rmsi_ctrl.sv =====
// controller state machine of the region membership set iterator
`timescale 1ns / 1ps

module rmsi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  rmsi_pkg::status_t status,
	output rmsi_pkg::cmd_t    cmd
);

	rmsi_pkg::state_t state_q;
	rmsi_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmsi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			rmsi_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (status.in_valid) begin
					state_nxt = rmsi_pkg::ST_DECODE;
				end
			end
			rmsi_pkg::ST_DECODE: begin
				cmd.load_addr = 1'b1;
				if (status.route == rmsi_pkg::ROUTE_DIRECT) begin
					state_nxt = rmsi_pkg::ST_DIRECT;
				end else begin
					state_nxt = rmsi_pkg::ST_FETCH;
				end
			end
			rmsi_pkg::ST_FETCH: begin
				cmd.rd_en = 1'b1;
				if (status.route == rmsi_pkg::ROUTE_SCAN) begin
					state_nxt = rmsi_pkg::ST_SCAN;
				end else begin
					state_nxt = rmsi_pkg::ST_EXEC;
				end
			end
			rmsi_pkg::ST_EXEC, rmsi_pkg::ST_DIRECT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = rmsi_pkg::ST_IDLE;
				end
			end
			rmsi_pkg::ST_SCAN: begin
				if (!status.scan_done) begin
					// keep the word reads streaming
					cmd.rd_en = 1'b1;
				end else if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = rmsi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rmsi_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rmsi_dpath.sv =====
// datapath: bitmap memory, counters, scan logic and result register
`timescale 1ns / 1ps

module rmsi_dpath #(
	parameter int MAX_REGIONS = rmsi_pkg::MAX_REGIONS_DEF,
	parameter int WORD_BITS   = rmsi_pkg::WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rmsi_req_if.sink          req,
	rmsi_rsp_if.source        rsp,
	rmsi_cfg_if.sink          cfg,
	input  rmsi_pkg::cmd_t    cmd,
	output rmsi_pkg::status_t status
);

	localparam int WORDS = (MAX_REGIONS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LOG_W = $clog2(WORD_BITS);
	localparam int PW    = $clog2(MAX_REGIONS + 1);

	// captured request
	rmsi_pkg::op_t                op_q;
	logic [rmsi_pkg::INDEX_W-1:0] idx_q;

	// architectural state
	logic [rmsi_pkg::CFG_W-1:0]   cfg_q;
	logic [PW-1:0]                count_q;
	logic [PW-1:0]                pos_q;

	// bitmap memory, one valid bit per word
	logic [WORD_BITS-1:0]         mem [WORDS];
	logic [WORDS-1:0]             wvalid_q;
	logic [WA_W-1:0]              addr_q;
	logic [WORD_BITS-1:0]         rd_data_s1;
	logic                         rd_valid_s1;
	logic [WA_W-1:0]              rd_word_s1;

	// result register
	logic                         rsp_valid_q;
	logic                         success_q;
	logic [rmsi_pkg::INDEX_W-1:0] found_q;
	logic                         exh_q;
	logic                         err_q;
	logic [rmsi_pkg::COUNT_W-1:0] cnt_out_q;

	logic [PW-1:0]                lim;
	logic                         in_range;
	logic                         pos_in_range;
	logic [WA_W-1:0]              idx_word;
	logic [LOG_W-1:0]             idx_bit;
	logic [WA_W-1:0]              pos_word;
	logic [LOG_W-1:0]             pos_bit;
	logic [31:0]                  last;
	logic [WA_W-1:0]              last_word;
	logic [LOG_W-1:0]             last_bit;
	logic [WORD_BITS-1:0]         word_cur;
	logic                         cur_bit;
	logic [WORD_BITS-1:0]         lo_mask;
	logic [WORD_BITS-1:0]         hi_mask;
	logic [WORD_BITS-1:0]         cand;
	logic                         hit;
	logic [LOG_W-1:0]             ffs;
	logic [31:0]                  found_g;
	logic                         scan_last;

	logic                         res_success;
	logic                         res_exh;
	logic                         res_err;
	logic [rmsi_pkg::INDEX_W-1:0] res_found;
	logic [PW-1:0]                count_nxt;
	logic [PW-1:0]                pos_nxt;
	logic                         wr_en;
	logic [WORD_BITS-1:0]         wr_data;
	logic                         clear_all;

	assign req.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;

	// effective limit: min(register, MAX_REGIONS)
	assign lim = (32'(cfg_q) > 32'(MAX_REGIONS)) ? PW'(MAX_REGIONS) : PW'(cfg_q);

	assign in_range     = 32'(idx_q) < 32'(lim);
	assign pos_in_range = 32'(pos_q) < 32'(lim);
	assign idx_word     = WA_W'(32'(idx_q) >> LOG_W);
	assign idx_bit      = LOG_W'(idx_q);
	assign pos_word     = WA_W'(32'(pos_q) >> LOG_W);
	assign pos_bit      = LOG_W'(pos_q);
	assign last         = 32'(lim) - 32'd1;
	assign last_word    = WA_W'(last >> LOG_W);
	assign last_bit     = LOG_W'(last);

	assign word_cur = rd_valid_s1 ? rd_data_s1 : '0;
	assign cur_bit  = word_cur[idx_bit];

	// scan window within the current word
	assign lo_mask = (rd_word_s1 == pos_word) ? ({WORD_BITS{1'b1}} << pos_bit)
		: {WORD_BITS{1'b1}};
	assign hi_mask = (rd_word_s1 == last_word)
		? ({WORD_BITS{1'b1}} >> (LOG_W'(WORD_BITS - 1) - last_bit)) : {WORD_BITS{1'b1}};
	assign cand = word_cur & lo_mask & hi_mask;

	// lowest set bit
	always_comb begin
		hit = 1'b0;
		ffs = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				hit = 1'b1;
				ffs = LOG_W'(i);
			end
		end
	end

	assign found_g   = (32'(rd_word_s1) << LOG_W) | 32'(ffs);
	assign scan_last = rd_word_s1 == last_word;

	always_comb begin
		status.in_valid  = req.valid;
		status.scan_done = hit || scan_last;
		status.out_free  = !rsp_valid_q || rsp.ready;
		unique case (op_q) inside
			rmsi_pkg::OP_ADD, rmsi_pkg::OP_REMOVE, rmsi_pkg::OP_QUERY: begin
				status.route = in_range ? rmsi_pkg::ROUTE_INDEX : rmsi_pkg::ROUTE_DIRECT;
			end
			rmsi_pkg::OP_ITER_NEXT: begin
				status.route = pos_in_range ? rmsi_pkg::ROUTE_SCAN : rmsi_pkg::ROUTE_DIRECT;
			end
			default: begin
				status.route = rmsi_pkg::ROUTE_DIRECT;
			end
		endcase
	end

	// result and state update of the operation being committed
	always_comb begin
		res_success = 1'b0;
		res_exh     = 1'b0;
		res_err     = 1'b0;
		res_found   = '0;
		count_nxt   = count_q;
		pos_nxt     = pos_q;
		wr_en       = 1'b0;
		wr_data     = word_cur;
		clear_all   = 1'b0;
		case (op_q)
			rmsi_pkg::OP_ADD: begin
				if (!in_range) begin
					res_err = 1'b1;
				end else if (!cur_bit) begin
					wr_en          = 1'b1;
					wr_data[idx_bit] = 1'b1;
					count_nxt      = count_q + PW'(1);
					res_success    = 1'b1;
				end
			end
			rmsi_pkg::OP_REMOVE: begin
				if (!in_range || !cur_bit) begin
					res_err = 1'b1;
				end else begin
					wr_en          = 1'b1;
					wr_data[idx_bit] = 1'b0;
					count_nxt      = count_q - PW'(1);
					res_success    = 1'b1;
				end
			end
			rmsi_pkg::OP_CLEAR: begin
				clear_all = 1'b1;
				count_nxt = '0;
			end
			rmsi_pkg::OP_QUERY: begin
				if (!in_range) begin
					res_err = 1'b1;
				end else begin
					res_success = cur_bit;
				end
			end
			rmsi_pkg::OP_ITER_RESET: begin
				pos_nxt = '0;
			end
			rmsi_pkg::OP_ITER_NEXT: begin
				if (pos_in_range && hit) begin
					res_success = 1'b1;
					res_found   = rmsi_pkg::INDEX_W'(found_g);
					pos_nxt     = PW'(found_g + 32'd1);
				end else begin
					res_exh = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= rmsi_pkg::op_t'(req.operation);
			idx_q <= req.region_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rmsi_pkg::CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cfg_q <= cfg.regions_in_use;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
			pos_q   <= pos_nxt;
		end
	end

	// word address: start word of the scan or word of the indexed region
	always_ff @(posedge clk) begin
		if (cmd.load_addr) begin
			addr_q <= (op_q == rmsi_pkg::OP_ITER_NEXT) ? pos_word : idx_word;
		end else if (cmd.rd_en) begin
			addr_q <= addr_q + WA_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1  <= mem[addr_q];
			rd_valid_s1 <= wvalid_q[addr_q];
			rd_word_s1  <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem[rd_word_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (cmd.commit && clear_all) begin
			wvalid_q <= '0;
		end else if (cmd.commit && wr_en) begin
			wvalid_q[rd_word_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			success_q <= res_success;
			found_q   <= res_found;
			exh_q     <= res_exh;
			err_q     <= res_err;
			cnt_out_q <= rmsi_pkg::COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.success      = success_q;
	assign rsp.found_index  = found_q;
	assign rsp.exhausted    = exh_q;
	assign rsp.error        = err_q;
	assign rsp.member_count = cnt_out_q;

endmodule

// ===== hdl/region_membership_set_iterator_top.sv =====
// top level of the region membership set iterator
`timescale 1ns / 1ps
`include "region_membership_set_iterator_top_defines.svh"

// region membership set with a forward iterator. one request is one operation
// (add, remove, clear, query, iterator reset, iterator next) and gives exactly one
// response. the membership bitmap lives in a memory of WORD_BITS-wide words with
// one read port and a registered read, so every bit access costs a memory read.
// the block works on one request at a time: add, remove and query pass from the
// accept through decode, word read and update before the response is loaded;
// clear, iterator reset, undefined codes and out-of-range indexes go from decode
// straight to the response with no word read. iterator next reads one word per
// clock from the iterator position up to the word holding the last region in use
// and stops at the first member, so it reads W words with W between 1 and
// ceil(regions_in_use / WORD_BITS), at most 16 words with 1024 regions of 64-bit
// words. a response waiting on rsp does not block the next request from being
// taken; the block only holds its commit until the response register is free.
// clear and reset empty the set at once through per-word valid bits, so there is
// no clearing pass. the user must write regions_in_use through cfg only while
// no request is in flight (not enforced by the block); it acts on the next request.
module region_membership_set_iterator_top #(
	parameter int MAX_REGIONS = rmsi_pkg::MAX_REGIONS_DEF,
	parameter int WORD_BITS   = rmsi_pkg::WORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rmsi_req_if.sink   req,
	rmsi_rsp_if.source rsp,
	rmsi_cfg_if.sink   cfg
);

	// command and status between controller and datapath
	rmsi_pkg::cmd_t    cmd;
	rmsi_pkg::status_t status;

	// sequencer: decode, word reads, scan stepping, commit
	rmsi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// bitmap memory, counters, scan logic and response register
	rmsi_dpath #(
		.MAX_REGIONS (MAX_REGIONS),
		.WORD_BITS   (WORD_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

	// a commit never overwrites a response that is still waiting
	`RMSI_ASSERT_IMP(a_commit_out_free, clk, arst_n, cmd.commit, (!rsp.valid || rsp.ready))
	// only one request in flight
	`RMSI_ASSERT_NXT(a_single_request, clk, arst_n, (req.valid && req.ready), !req.ready)
	// success excludes exhausted and error
	`RMSI_ASSERT_IMP(a_flags_exclusive, clk, arst_n, (rsp.valid && rsp.success), (!rsp.exhausted && !rsp.error))
	// found index is zero unless a member was returned
	`RMSI_ASSERT_IMP(a_found_zero, clk, arst_n, (rsp.valid && !rsp.success), (rsp.found_index == '0))

endmodule
